>>> rtl/utfdf_pkg.sv
`timescale 1ns / 1ps
package utfdf_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_MAX_OUT = 1'b0;
  localparam logic CFG_MAX_IN  = 1'b1;

  localparam logic [7:0] MAX_OUT_RESET = 8'd159;
  localparam logic [7:0] MAX_IN_RESET  = 8'd191;

  // Terminator status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY_IN  = 2'd1;
  localparam logic [1:0] ST_EMPTY_OUT = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One accepted request as seen by the back end: up to three encoded
  // bytes and an optional terminator
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       term;
    logic [1:0] status;
    logic [7:0] base;
  } rec_t;

  // Quote and markdown code points
  function automatic logic cp_removed(input logic [20:0] cp);
    return cp == 21'h22 || cp == 21'h60 || cp == 21'h2A || cp == 21'h23 ||
           cp == 21'h2018 || cp == 21'h2019 || cp == 21'h201C ||
           cp == 21'h201D || (cp >= 21'h300C && cp <= 21'h300F);
  endfunction

  // Newline, printable ASCII, kana, CJK and three punctuation marks
  function automatic logic cp_kept(input logic [20:0] cp);
    return cp == 21'h0A ||
           (cp >= 21'h20 && cp <= 21'h7E) ||
           (cp >= 21'h3040 && cp <= 21'h30FF) ||
           (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
           cp == 21'h3001 || cp == 21'h3002 || cp == 21'h30FC;
  endfunction

endpackage

>>> rtl/utfdf_front.sv
`timescale 1ns / 1ps
module utfdf_front import utfdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output rec_t       rec
);

  logic [7:0]  max_out;
  logic [7:0]  max_in;
  logic [1:0]  pend, pend_next;
  logic [20:0] part, part_next;
  logic [7:0]  in_cnt, in_cnt_next;
  logic [7:0]  out_cnt, out_cnt_next;
  logic        full, full_next;
  logic        ended, ended_next;

  logic        take;
  logic        cont;
  logic [20:0] part_app;
  logic [20:0] cp, cp_f;
  logic        cp_valid;
  logic        emit_ok;
  logic [1:0]  n;
  logic [7:0]  e0, e1, e2;
  logic        fits;
  logic [1:0]  nbytes;
  logic [1:0]  status;

  assign take     = !ended && (in_cnt < max_in);
  assign cont     = in_byte[7:6] == 2'b10;
  assign part_app = {part[14:0], in_byte[5:0]};

  // Decode one byte and advance the sequence state
  always_comb begin
    pend_next   = pend;
    part_next   = part;
    in_cnt_next = in_cnt;
    ended_next  = ended;
    cp          = '0;
    cp_valid    = 1'b0;
    if (take) begin
      if (in_byte == 8'h00) begin
        ended_next = 1'b1;
        pend_next  = '0;
        part_next  = '0;
      end else begin
        in_cnt_next = in_cnt + 8'd1;
        if (pend != 2'd0 && cont) begin
          pend_next = pend - 2'd1;
          if (pend == 2'd1) begin
            cp        = part_app;
            cp_valid  = 1'b1;
            part_next = '0;
          end else begin
            part_next = part_app;
          end
        end else begin
          // drop any broken sequence and retry this byte as a lead
          pend_next = '0;
          part_next = '0;
          if (!in_byte[7]) begin
            cp       = {13'd0, in_byte};
            cp_valid = 1'b1;
          end else if (in_byte[7:5] == 3'b110) begin
            part_next = {16'd0, in_byte[4:0]};
            pend_next = 2'd1;
          end else if (in_byte[7:4] == 4'b1110) begin
            part_next = {17'd0, in_byte[3:0]};
            pend_next = 2'd2;
          end else if (in_byte[7:3] == 5'b11110) begin
            part_next = {18'd0, in_byte[2:0]};
            pend_next = 2'd3;
          end
        end
      end
    end
  end

  // Filter and re-encode the code point
  always_comb begin
    cp_f    = (cp == 21'h09) ? 21'h20 : cp;
    emit_ok = cp_valid && !cp_removed(cp) && cp_kept(cp_f) && !full;
    if (cp_f < 21'h80) begin
      n  = 2'd1;
      e0 = cp_f[7:0];
      e1 = '0;
      e2 = '0;
    end else if (cp_f < 21'h800) begin
      n  = 2'd2;
      e0 = {3'b110, cp_f[10:6]};
      e1 = {2'b10, cp_f[5:0]};
      e2 = '0;
    end else begin
      n  = 2'd3;
      e0 = {4'b1110, cp_f[15:12]};
      e1 = {2'b10, cp_f[11:6]};
      e2 = {2'b10, cp_f[5:0]};
    end
    fits = ({1'b0, out_cnt} + {7'd0, n}) <= {1'b0, max_out};
  end

  // Count output bytes, mark the output full, build the status
  always_comb begin
    out_cnt_next = out_cnt;
    full_next    = full;
    nbytes       = '0;
    if (emit_ok) begin
      if (fits) begin
        out_cnt_next = out_cnt + {6'd0, n};
        nbytes       = n;
      end else begin
        full_next = 1'b1;
      end
    end
    if (in_cnt_next == 8'd0) begin
      status = ST_EMPTY_IN;
    end else if (out_cnt_next == 8'd0) begin
      status = ST_EMPTY_OUT;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    rec.b0     = e0;
    rec.b1     = e1;
    rec.b2     = e2;
    rec.nbytes = nbytes;
    rec.term   = in_last;
    rec.status = status;
    rec.base   = out_cnt;
  end

  assign push = accept && (nbytes != 2'd0 || in_last);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out <= MAX_OUT_RESET;
      max_in  <= MAX_IN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_OUT: max_out <= cfg_data;
        CFG_MAX_IN:  max_in  <= cfg_data;
        default:     max_out <= max_out;
      endcase
    end
  end

  // Advance message state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      part    <= '0;
      in_cnt  <= '0;
      out_cnt <= '0;
      full    <= 1'b0;
      ended   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        pend    <= '0;
        part    <= '0;
        in_cnt  <= '0;
        out_cnt <= '0;
        full    <= 1'b0;
        ended   <= 1'b0;
      end else begin
        pend    <= pend_next;
        part    <= part_next;
        in_cnt  <= in_cnt_next;
        out_cnt <= out_cnt_next;
        full    <= full_next;
        ended   <= ended_next;
      end
    end
  end

  a_ended_no_pend: assert property (@(posedge clk) disable iff (rst)
    ended |-> pend == 2'd0)
    else $error("sequence pending after end of text");

endmodule

>>> rtl/utfdf_queue.sv
`timescale 1ns / 1ps
module utfdf_queue import utfdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic not_empty,
  output logic not_full
);

  rec_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;
  assign not_full  = count != (QPTR_W + 1)'(QUEUE_DEPTH);

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !not_full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("queue read while empty");

endmodule

>>> rtl/utfdf_back.sv
`timescale 1ns / 1ps
module utfdf_back import utfdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rec_t        head,
  input  logic        head_valid,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  rec_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [2:0] total;
  logic       last_of_rec;
  logic       fire;
  logic       is_term;
  logic [7:0] byte_sel;
  logic [7:0] cnt;
  logic [1:0] status;

  assign total       = {1'b0, cur.nbytes} + {2'd0, cur.term};
  assign last_of_rec = ({1'b0, idx} + 3'd1) == total;
  assign fire        = cur_valid && m_tready;
  assign pop         = head_valid && (!cur_valid || (fire && last_of_rec));

  // Pick the result for the current index
  always_comb begin
    is_term = idx == cur.nbytes;
    case (idx)
      2'd0:    byte_sel = cur.b0;
      2'd1:    byte_sel = cur.b1;
      2'd2:    byte_sel = cur.b2;
      default: byte_sel = 8'h00;
    endcase
    if (is_term) begin
      byte_sel = 8'h00;
      cnt      = cur.base + {6'd0, cur.nbytes};
      status   = cur.status;
    end else begin
      cnt    = cur.base + {6'd0, idx} + 8'd1;
      status = ST_OK;
    end
  end

  assign m_tvalid = cur_valid;
  assign m_tlast  = is_term;
  assign m_tdata  = {6'd0, cnt, status, byte_sel};

  // Load the next request or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (fire) begin
      if (last_of_rec) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  a_rec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> total != 3'd0)
    else $error("empty request loaded");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> {1'b0, idx} < total)
    else $error("result index past end of request");

endmodule

>>> rtl/utf8_display_text_filter.sv
`timescale 1ns / 1ps
// UTF-8 display text filter.
// Input stream (s_*): one text byte per request, s_tlast on the final byte
// of a message. Output stream (m_*): one result per kept UTF-8 byte, then
// a terminator (m_tlast high, byte zero) carrying the message status.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 max_output_bytes, 1 max_input_bytes); write only while idle.
// Throughput: one input byte per cycle and one result per cycle while
// m_tready is high. A byte may expand to three results plus a terminator;
// the four-entry queue between decoder and serializer absorbs these
// bursts, and s_tready drops only while that queue is full.
// Path: the results of a byte are registered by the queue write and then
// by the serializer load before they appear on m_*.
// Reset (rst, synchronous): limits return to 159 output and 191 input
// bytes, message state and queue are cleared.
// When m_tready is low, results hold on m_* and input keeps flowing until
// the queue fills.
module utf8_display_text_filter import utfdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [9:8] status, [17:10] byte_count
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic accept;
  logic push;
  rec_t push_rec;
  logic pop;
  rec_t head;
  logic not_empty;
  logic not_full;

  assign s_tready = not_full;
  assign accept   = s_tvalid && not_full;

  utfdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .rec       (push_rec)
  );

  utfdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .not_full  (not_full)
  );

  utfdf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
